@@ rtl/sine_cosine_tangent_unit_core_assert.svh @@
// Assertion helpers for the sine, cosine and tangent core.
// Both expect clk and arst_n in the scope of use.
`ifndef SINE_COSINE_TANGENT_UNIT_CORE_ASSERT_SVH
`define SINE_COSINE_TANGENT_UNIT_CORE_ASSERT_SVH

// Same-cycle implication.
`define SCTU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SCTU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sctu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sctu_pkg;

	localparam int SERIES_TERMS = 12;
	localparam int OUT_W = 48;

	// Function select codes
	localparam logic [1:0] MODE_SIN = 2'd0;
	localparam logic [1:0] MODE_COS = 2'd1;
	localparam logic [1:0] MODE_TAN = 2'd2;

	// Q56 constants
	localparam logic [63:0] TWO_PI_Q56  = 64'h0648_7ED5_110B_4612;
	localparam logic [57:0] PI_Q56      = 58'h324_3F6A_8885_A309;
	localparam logic [56:0] HALF_PI_Q56 = 57'h192_1FB5_4442_D184;
	localparam logic [56:0] ONE_Q56     = 57'h100_0000_0000_0000;
	localparam logic [56:0] POLE_Q56    = 57'd72058;
	localparam logic [47:0] OUT_MAX     = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] OUT_MIN     = 48'h8000_0000_0001;

	// Reciprocals ceil(2^69 / d) for the series divisors, exact for numerators below 2^59
	localparam int RECIP_SHIFT = 69;
	localparam logic [69:0] RECIP_NUM = 70'd1 << RECIP_SHIFT;

	localparam logic [68:0] RECIP_SIN [16] = '{
		69'd0,
		69'((RECIP_NUM + 70'd5) / 70'd6),
		69'((RECIP_NUM + 70'd19) / 70'd20),
		69'((RECIP_NUM + 70'd41) / 70'd42),
		69'((RECIP_NUM + 70'd71) / 70'd72),
		69'((RECIP_NUM + 70'd109) / 70'd110),
		69'((RECIP_NUM + 70'd155) / 70'd156),
		69'((RECIP_NUM + 70'd209) / 70'd210),
		69'((RECIP_NUM + 70'd271) / 70'd272),
		69'((RECIP_NUM + 70'd341) / 70'd342),
		69'((RECIP_NUM + 70'd419) / 70'd420),
		69'((RECIP_NUM + 70'd505) / 70'd506),
		69'((RECIP_NUM + 70'd599) / 70'd600),
		69'((RECIP_NUM + 70'd701) / 70'd702),
		69'((RECIP_NUM + 70'd811) / 70'd812),
		69'((RECIP_NUM + 70'd929) / 70'd930)
	};

	localparam logic [68:0] RECIP_COS [16] = '{
		69'd0,
		69'((RECIP_NUM + 70'd1) / 70'd2),
		69'((RECIP_NUM + 70'd11) / 70'd12),
		69'((RECIP_NUM + 70'd29) / 70'd30),
		69'((RECIP_NUM + 70'd55) / 70'd56),
		69'((RECIP_NUM + 70'd89) / 70'd90),
		69'((RECIP_NUM + 70'd131) / 70'd132),
		69'((RECIP_NUM + 70'd181) / 70'd182),
		69'((RECIP_NUM + 70'd239) / 70'd240),
		69'((RECIP_NUM + 70'd305) / 70'd306),
		69'((RECIP_NUM + 70'd379) / 70'd380),
		69'((RECIP_NUM + 70'd461) / 70'd462),
		69'((RECIP_NUM + 70'd551) / 70'd552),
		69'((RECIP_NUM + 70'd649) / 70'd650),
		69'((RECIP_NUM + 70'd755) / 70'd756),
		69'((RECIP_NUM + 70'd869) / 70'd870)
	};

	// Series state between term stages; the pending terms are not yet in the sums
	typedef struct packed {
		logic [1:0]  mode;
		logic [57:0] x2;
		logic [56:0] s_mag;
		logic        s_sgn;
		logic [56:0] c_mag;
		logic        c_sgn;
		logic [63:0] s_sum;
		logic [63:0] c_sum;
	} term_rec_t;

	// Add a signed term given as magnitude and sign
	function automatic logic [63:0] add_term(logic [63:0] sum, logic [56:0] mag, logic neg);
		logic [63:0] ext;
		ext = {7'd0, mag};
		return neg ? sum - ext : sum + ext;
	endfunction

endpackage
`default_nettype wire

@@ rtl/sctu_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface sctu_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [31:0] angle;

	modport source (output valid, output mode, output angle, input ready);
	modport sink (input valid, input mode, input angle, output ready);
endinterface
`default_nettype wire

@@ rtl/sctu_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface sctu_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] result;
	logic               saturated;

	modport source (output valid, output result, output saturated, input ready);
	modport sink (input valid, input result, input saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/sctu_term.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One Taylor step for the sine and cosine lanes: fold the pending term into the sum,
// then form the next term as (term * x^2 >> 56) / d over four stages.
module sctu_term (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [3:0]          idx,
	input  logic                up_vld,
	input  sctu_pkg::term_rec_t up_rec,
	output logic                dn_vld,
	output sctu_pkg::term_rec_t dn_rec
);
	import sctu_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	term_rec_t rec_s1, rec_s2, rec_s3, rec_s4;

	// Partial products of term times x^2
	logic [63:0] sp00_s1, cp00_s1;
	logic [57:0] sp01_s1, cp01_s1;
	logic [56:0] sp10_s1, cp10_s1;
	logic [50:0] sp11_s1, cp11_s1;

	logic [58:0] sn_s2, cn_s2;

	// Partial products of quotient estimate
	logic [63:0] sq00_s3, sq01_s3, cq00_s3, cq01_s3;
	logic [36:0] sq02_s3, cq02_s3;
	logic [58:0] sq10_s3, sq11_s3, cq10_s3, cq11_s3;
	logic [31:0] sq12_s3, cq12_s3;

	term_rec_t   nxt_s1, nxt_s4;
	logic [114:0] sfull, cfull;
	logic [127:0] sprod, cprod;
	logic [68:0]  s_recip, c_recip;

	// Accumulate pending terms, flip sign for the next term
	always_comb begin
		nxt_s1 = up_rec;
		nxt_s1.s_sum = add_term(up_rec.s_sum, up_rec.s_mag, up_rec.s_sgn);
		nxt_s1.c_sum = add_term(up_rec.c_sum, up_rec.c_mag, up_rec.c_sgn);
		nxt_s1.s_sgn = !up_rec.s_sgn;
		nxt_s1.c_sgn = !up_rec.c_sgn;
	end

	// Sum partial products and keep bits above 2^-56
	always_comb begin
		sfull = 115'(sp00_s1) + (115'(sp01_s1) << 32) + (115'(sp10_s1) << 32)
			+ (115'(sp11_s1) << 64);
		cfull = 115'(cp00_s1) + (115'(cp01_s1) << 32) + (115'(cp10_s1) << 32)
			+ (115'(cp11_s1) << 64);
	end

	assign s_recip = RECIP_SIN[idx];
	assign c_recip = RECIP_COS[idx];

	// Reciprocal product, quotient sits above the shift
	always_comb begin
		sprod = 128'(sq00_s3) + (128'(sq01_s3) << 32) + (128'(sq02_s3) << 64)
			+ (128'(sq10_s3) << 32) + (128'(sq11_s3) << 64) + (128'(sq12_s3) << 96);
		cprod = 128'(cq00_s3) + (128'(cq01_s3) << 32) + (128'(cq02_s3) << 64)
			+ (128'(cq10_s3) << 32) + (128'(cq11_s3) << 64) + (128'(cq12_s3) << 96);
		nxt_s4 = rec_s3;
		nxt_s4.s_mag = sprod[RECIP_SHIFT+56:RECIP_SHIFT];
		nxt_s4.c_mag = cprod[RECIP_SHIFT+56:RECIP_SHIFT];
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= up_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s1  <= nxt_s1;
			sp00_s1 <= up_rec.s_mag[31:0] * up_rec.x2[31:0];
			sp01_s1 <= up_rec.s_mag[31:0] * up_rec.x2[57:32];
			sp10_s1 <= up_rec.s_mag[56:32] * up_rec.x2[31:0];
			sp11_s1 <= up_rec.s_mag[56:32] * up_rec.x2[57:32];
			cp00_s1 <= up_rec.c_mag[31:0] * up_rec.x2[31:0];
			cp01_s1 <= up_rec.c_mag[31:0] * up_rec.x2[57:32];
			cp10_s1 <= up_rec.c_mag[56:32] * up_rec.x2[31:0];
			cp11_s1 <= up_rec.c_mag[56:32] * up_rec.x2[57:32];

			rec_s2 <= rec_s1;
			sn_s2  <= sfull[114:56];
			cn_s2  <= cfull[114:56];

			rec_s3  <= rec_s2;
			sq00_s3 <= sn_s2[31:0] * s_recip[31:0];
			sq01_s3 <= sn_s2[31:0] * s_recip[63:32];
			sq02_s3 <= sn_s2[31:0] * s_recip[68:64];
			sq10_s3 <= sn_s2[58:32] * s_recip[31:0];
			sq11_s3 <= sn_s2[58:32] * s_recip[63:32];
			sq12_s3 <= sn_s2[58:32] * s_recip[68:64];
			cq00_s3 <= cn_s2[31:0] * c_recip[31:0];
			cq01_s3 <= cn_s2[31:0] * c_recip[63:32];
			cq02_s3 <= cn_s2[31:0] * c_recip[68:64];
			cq10_s3 <= cn_s2[58:32] * c_recip[31:0];
			cq11_s3 <= cn_s2[58:32] * c_recip[63:32];
			cq12_s3 <= cn_s2[58:32] * c_recip[68:64];

			rec_s4 <= nxt_s4;
		end
	end

	assign dn_vld = vld_s4;
	assign dn_rec = rec_s4;

endmodule
`default_nettype wire

@@ rtl/sine_cosine_tangent_unit_core.sv @@
// Sine, cosine and tangent of a Q8.24 angle in radians, result in Q16.32. The core is a
// fully pipelined datapath that takes one beat per cycle while the output is not stalled and
// returns one result beat per input beat, in order. Its stages are one input stage, five of turn
// reduction, two of folding, two for x^2, four per series term (one multiplier pass for the
// product, one for the divide by a reciprocal), three to finish the sums, 48 of restoring
// division for the tangent quotient, and the output register. A stall at the output freezes
// the whole pipeline; nothing is dropped or repeated. Tangent saturates to the signed maximum
// with the sign of the sine near a pole or when the quotient leaves the output range, and
// raises saturated. Mode 3 returns zero.
`timescale 1ns / 1ps
`default_nettype none
`include "sine_cosine_tangent_unit_core_assert.svh"
module sine_cosine_tangent_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	sctu_in_if.sink     cmd,
	sctu_out_if.source  res
);
	import sctu_pkg::*;

	typedef struct packed {
		logic [1:0]  mode;
		logic        s_neg;
		logic        c_neg;
		logic        sat;
		logic [47:0] trig;
		logic [56:0] uc;
		logic [15:0] us_lo;
		logic [56:0] rem;
		logic [47:0] q;
	} div_rec_t;

	localparam int RED_STEPS = 5;

	logic adv;

	logic        red_vld_s  [RED_STEPS+1];
	logic [63:0] red_rem_s  [RED_STEPS+1];
	logic        red_neg_s  [RED_STEPS+1];
	logic [1:0]  red_mode_s [RED_STEPS+1];

	logic        f1_vld_s, f2_vld_s;
	logic [57:0] f1_mag_s;
	logic        f1_neg_s;
	logic [1:0]  f1_mode_s, f2_mode_s;
	logic [56:0] f2_mag_s;
	logic        f2_neg_s, f2_cneg_s;

	logic        sq_vld_s1, sq_vld_s2;
	logic [63:0] sq00_s1;
	logic [56:0] sq01_s1;
	logic [49:0] sq11_s1;
	logic [56:0] sq_mag_s1;
	logic        sq_neg_s1, sq_cneg_s1;
	logic [1:0]  sq_mode_s1;
	term_rec_t   sq_rec_s2;

	logic        term_vld [SERIES_TERMS];
	term_rec_t   term_rec [SERIES_TERMS];

	logic        fn_vld_s, t0_vld_s;
	logic [63:0] fn_s_s, fn_c_s;
	logic [1:0]  fn_mode_s, t0_mode_s;
	logic [56:0] t0_us_s, t0_uc_s;
	logic        t0_s_neg_s, t0_c_neg_s;

	logic        dv_vld_s [OUT_W+1];
	div_rec_t    dv_s     [OUT_W+1];

	logic        out_vld_q;
	logic [47:0] result_q;
	logic        sat_q;

	logic [31:0]  ang_mag;
	logic [57:0]  f1_nxt;
	logic         f1_flip;
	logic [114:0] sq_full;
	term_rec_t    last_rec;
	logic [63:0]  s_abs, c_abs;
	logic [56:0]  trig_mag;
	logic         trig_neg;
	logic [32:0]  trig_m;
	div_rec_t     dv0;
	div_rec_t     dv_last;
	logic         fin_sat;
	logic [47:0]  fin_res;

	// Global advance: move when the output register is free or being taken
	assign adv = !out_vld_q || res.ready;
	assign cmd.ready = adv;

	// Input stage: angle magnitude placed in Q56
	assign ang_mag = cmd.angle[31] ? 32'd0 - cmd.angle : cmd.angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_vld_s[0] <= 1'b0;
		end else if (adv) begin
			red_vld_s[0] <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_rem_s[0]  <= {ang_mag, 32'd0};
			red_neg_s[0]  <= cmd.angle[31];
			red_mode_s[0] <= cmd.mode;
		end
	end

	// Reduce by whole turns, one quotient bit per stage
	for (genvar k = 1; k <= RED_STEPS; k++) begin : g_red
		localparam logic [63:0] SUB = TWO_PI_Q56 << (RED_STEPS - k);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				red_vld_s[k] <= 1'b0;
			end else if (adv) begin
				red_vld_s[k] <= red_vld_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				red_rem_s[k]  <= (red_rem_s[k-1] >= SUB) ? red_rem_s[k-1] - SUB
					: red_rem_s[k-1];
				red_neg_s[k]  <= red_neg_s[k-1];
				red_mode_s[k] <= red_mode_s[k-1];
			end
		end
	end

	// Mirror the upper half turn
	assign f1_flip = red_rem_s[RED_STEPS] > 64'(PI_Q56);
	assign f1_nxt  = f1_flip ? 58'(TWO_PI_Q56 - red_rem_s[RED_STEPS])
		: red_rem_s[RED_STEPS][57:0];

	// Fold into the half-pi range and square the magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1_vld_s  <= 1'b0;
			f2_vld_s  <= 1'b0;
			sq_vld_s1 <= 1'b0;
			sq_vld_s2 <= 1'b0;
		end else if (adv) begin
			f1_vld_s  <= red_vld_s[RED_STEPS];
			f2_vld_s  <= f1_vld_s;
			sq_vld_s1 <= f2_vld_s;
			sq_vld_s2 <= sq_vld_s1;
		end
	end

	assign sq_full = 115'(sq00_s1) + (115'(sq01_s1) << 33) + (115'(sq11_s1) << 64);

	always_ff @(posedge clk) begin
		if (adv) begin
			f1_mag_s  <= f1_nxt;
			f1_neg_s  <= red_neg_s[RED_STEPS] ^ f1_flip;
			f1_mode_s <= red_mode_s[RED_STEPS];

			if (f1_mag_s > 58'(HALF_PI_Q56)) begin
				f2_mag_s  <= 57'(PI_Q56 - f1_mag_s);
				f2_cneg_s <= 1'b1;
			end else begin
				f2_mag_s  <= f1_mag_s[56:0];
				f2_cneg_s <= 1'b0;
			end
			f2_neg_s  <= f1_neg_s;
			f2_mode_s <= f1_mode_s;

			sq00_s1    <= f2_mag_s[31:0] * f2_mag_s[31:0];
			sq01_s1    <= f2_mag_s[31:0] * f2_mag_s[56:32];
			sq11_s1    <= f2_mag_s[56:32] * f2_mag_s[56:32];
			sq_mag_s1  <= f2_mag_s;
			sq_neg_s1  <= f2_neg_s;
			sq_cneg_s1 <= f2_cneg_s;
			sq_mode_s1 <= f2_mode_s;

			sq_rec_s2.mode  <= sq_mode_s1;
			sq_rec_s2.x2    <= sq_full[113:56];
			sq_rec_s2.s_mag <= sq_mag_s1;
			sq_rec_s2.s_sgn <= sq_neg_s1;
			sq_rec_s2.c_mag <= ONE_Q56;
			sq_rec_s2.c_sgn <= sq_cneg_s1;
			sq_rec_s2.s_sum <= 64'd0;
			sq_rec_s2.c_sum <= 64'd0;
		end
	end

	// Series term chain
	assign term_vld[0] = sq_vld_s2;
	assign term_rec[0] = sq_rec_s2;

	for (genvar g = 1; g < SERIES_TERMS; g++) begin : g_term
		sctu_term u_term (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.idx    (4'(g)),
			.up_vld (term_vld[g-1]),
			.up_rec (term_rec[g-1]),
			.dn_vld (term_vld[g]),
			.dn_rec (term_rec[g])
		);
	end

	assign last_rec = term_rec[SERIES_TERMS-1];
	assign s_abs = fn_s_s[63] ? 64'd0 - fn_s_s : fn_s_s;
	assign c_abs = fn_c_s[63] ? 64'd0 - fn_c_s : fn_c_s;

	// Close the sums, take magnitudes, set up the divider
	always_comb begin
		trig_mag = (t0_mode_s == MODE_COS) ? t0_uc_s : t0_us_s;
		trig_neg = (t0_mode_s == MODE_COS) ? t0_c_neg_s : t0_s_neg_s;
		trig_m   = trig_mag[56:24];
		dv0.mode  = t0_mode_s;
		dv0.s_neg = t0_s_neg_s;
		dv0.c_neg = t0_c_neg_s;
		dv0.sat   = (t0_uc_s < POLE_Q56) || ({16'd0, t0_us_s} >= {t0_uc_s, 16'd0});
		dv0.trig  = trig_neg ? 48'd0 - 48'(trig_m) : 48'(trig_m);
		dv0.uc    = t0_uc_s;
		dv0.us_lo = t0_us_s[15:0];
		dv0.rem   = 57'(t0_us_s[56:16]);
		dv0.q     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fn_vld_s    <= 1'b0;
			t0_vld_s    <= 1'b0;
			dv_vld_s[0] <= 1'b0;
		end else if (adv) begin
			fn_vld_s    <= term_vld[SERIES_TERMS-1];
			t0_vld_s    <= fn_vld_s;
			dv_vld_s[0] <= t0_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fn_s_s    <= add_term(last_rec.s_sum, last_rec.s_mag, last_rec.s_sgn);
			fn_c_s    <= add_term(last_rec.c_sum, last_rec.c_mag, last_rec.c_sgn);
			fn_mode_s <= last_rec.mode;

			t0_us_s    <= s_abs[56:0];
			t0_uc_s    <= c_abs[56:0];
			t0_s_neg_s <= fn_s_s[63];
			t0_c_neg_s <= fn_c_s[63];
			t0_mode_s  <= fn_mode_s;

			dv_s[0] <= dv0;
		end
	end

	// Restoring division of |s| * 2^32 by |c|, one quotient bit per stage
	for (genvar k = 1; k <= OUT_W; k++) begin : g_div
		localparam int BIT = OUT_W - k;
		logic        rbit;
		logic [57:0] rsh;
		logic        take;
		div_rec_t    nxt;

		if (BIT >= 32) begin : g_num
			assign rbit = dv_s[k-1].us_lo[BIT-32];
		end else begin : g_zero
			assign rbit = 1'b0;
		end

		assign rsh  = {dv_s[k-1].rem, rbit};
		assign take = rsh >= {1'b0, dv_s[k-1].uc};

		always_comb begin
			nxt = dv_s[k-1];
			if (take) begin
				nxt.rem = 57'(rsh - {1'b0, dv_s[k-1].uc});
			end else begin
				nxt.rem = rsh[56:0];
			end
			nxt.q = {dv_s[k-1].q[OUT_W-2:0], take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[k] <= dv_vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k] <= nxt;
			end
		end
	end

	// Select the result per mode
	assign dv_last = dv_s[OUT_W];

	always_comb begin
		fin_sat = 1'b0;
		fin_res = '0;
		case (dv_last.mode)
			MODE_SIN, MODE_COS: begin
				fin_res = dv_last.trig;
			end
			MODE_TAN: begin
				fin_sat = dv_last.sat || dv_last.q[OUT_W-1];
				if (fin_sat) begin
					fin_res = dv_last.s_neg ? OUT_MIN : OUT_MAX;
				end else begin
					fin_res = (dv_last.s_neg ^ dv_last.c_neg) ? 48'd0 - dv_last.q
						: dv_last.q;
				end
			end
			default: begin
				fin_res = '0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= dv_vld_s[OUT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= fin_res;
			sat_q    <= fin_sat;
		end
	end

	assign res.valid     = out_vld_q;
	assign res.result    = result_q;
	assign res.saturated = sat_q;

	`SCTU_ASSERT_IMP(a_red_range, red_vld_s[RED_STEPS], red_rem_s[RED_STEPS] < TWO_PI_Q56,
		"turn reduction left a remainder of a full turn or more")
	`SCTU_ASSERT_IMP(a_fold_range, f2_vld_s, f2_mag_s <= HALF_PI_Q56,
		"folded angle exceeds half pi")
	`SCTU_ASSERT_IMP(a_div_rem, dv_vld_s[OUT_W] && dv_last.mode == MODE_TAN && !dv_last.sat,
		dv_last.rem < dv_last.uc, "division remainder not below divisor")
	`SCTU_ASSERT_IMP(a_sat_value, dv_vld_s[OUT_W] && fin_sat,
		dv_last.mode == MODE_TAN && (fin_res == OUT_MAX || fin_res == OUT_MIN),
		"saturated result is not the signed limit of a tangent")
	`SCTU_ASSERT_NXT(a_advance, red_vld_s[0] && adv, red_vld_s[1],
		"beat lost between input and reduction stages")

endmodule
`default_nettype wire

@@ test/sine_cosine_tangent_unit_core_tb.sv @@
`timescale 1ns / 1ps
module sine_cosine_tangent_unit_core_tb;
	import sctu_pkg::*;

	localparam logic [1:0] MODE_RSVD = 2'd3;
	localparam int PIPE_DEPTH = 62 + 4 * (SERIES_TERMS - 1);
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 500;
	// Q8.24 angles at quarter, half and full turns
	localparam int ANG_HALF_PI = 26353589;
	localparam int ANG_PI = 52707179;
	localparam int ANG_TWO_PI = 105414357;

	typedef struct {
		logic signed [47:0] result;
		logic               saturated;
	} trig_out_t;

	logic clk;
	logic arst_n;

	sctu_in_if  cmd ();
	sctu_out_if res ();

	sine_cosine_tangent_unit_core u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd.sink),
		.res   (res.source)
	);

	trig_out_t trig_expected[$];
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int mismatches;
	int failed;
	int idle_cycles;
	int mode_count[4];
	int sat_count;
	int checked;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Signed Q56 product, magnitude truncated toward zero
	function automatic longint q56_mul(longint a, longint b);
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] prod;
		logic [63:0]  r;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		prod = ua * ub;
		r = {1'b0, prod[118:56]};
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint sine_sum(longint x);
		longint term;
		longint sum;
		longint x2;
		longint d;
		term = x;
		sum = x;
		x2 = q56_mul(x, x);
		for (int i = 1; i < SERIES_TERMS; i++) begin
			d = longint'(2 * i) * longint'(2 * i + 1);
			term = -(q56_mul(term, x2) / d);
			sum += term;
		end
		return sum;
	endfunction

	function automatic longint cosine_sum(longint x, logic flip);
		longint term;
		longint sum;
		longint x2;
		longint d;
		term = flip ? -(longint'(1) <<< 56) : (longint'(1) <<< 56);
		sum = term;
		x2 = q56_mul(x, x);
		for (int i = 1; i < SERIES_TERMS; i++) begin
			d = longint'(2 * i - 1) * longint'(2 * i);
			term = -(q56_mul(term, x2) / d);
			sum += term;
		end
		return sum;
	endfunction

	function automatic logic [47:0] q56_to_q32(longint v);
		logic [63:0] m;
		m = v < 0 ? -v : v;
		m = m >> 24;
		return v < 0 ? 48'(-m) : 48'(m);
	endfunction

	function automatic trig_out_t trig_predict(logic [1:0] m, logic signed [31:0] a);
		trig_out_t   o;
		logic        neg;
		logic        cflip;
		logic [63:0] mag;
		logic [63:0] r;
		longint      x;
		longint      s;
		longint      c;
		logic [63:0] us;
		logic [63:0] uc;
		logic [127:0] q;
		neg = a[31];
		mag = neg ? 64'h1_0000_0000 - {32'd0, a} : {32'd0, a};
		r = (mag << 32) % TWO_PI_Q56;
		cflip = 1'b0;
		if (r > 64'(PI_Q56)) begin
			r = TWO_PI_Q56 - r;
			neg = ~neg;
		end
		x = neg ? -longint'(r) : longint'(r);
		if (x > longint'(HALF_PI_Q56)) begin
			x = longint'(PI_Q56) - x;
			cflip = 1'b1;
		end else if (x < -longint'(HALF_PI_Q56)) begin
			x = -longint'(PI_Q56) - x;
			cflip = 1'b1;
		end
		o.result = '0;
		o.saturated = 1'b0;
		case (m)
			MODE_SIN: o.result = q56_to_q32(sine_sum(x));
			MODE_COS: o.result = q56_to_q32(cosine_sum(x, cflip));
			MODE_TAN: begin
				s = sine_sum(x);
				c = cosine_sum(x, cflip);
				us = s < 0 ? -s : s;
				uc = c < 0 ? -c : c;
				if (uc < 64'(POLE_Q56)) begin
					o.saturated = 1'b1;
				end else begin
					q = {64'd0, us} << 32;
					q = q / {64'd0, uc};
					o.saturated = q > 128'(OUT_MAX);
					if (!o.saturated)
						o.result = ((s < 0) != (c < 0)) ? -q[47:0] : q[47:0];
				end
				if (o.saturated)
					o.result = s < 0 ? -OUT_MAX : OUT_MAX;
			end
			default: ;
		endcase
		return o;
	endfunction

	// Offer one beat, with random gaps ahead of it; valid stays high after acceptance
	task automatic send_beat(logic [1:0] m, logic signed [31:0] a);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.mode <= m;
		cmd.angle <= a;
		do @(posedge clk); while (!cmd.ready);
		trig_expected.push_back(trig_predict(m, a));
		mode_count[m]++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		cmd.valid <= 1'b0;
	endtask

	// Hold the sender until every expected beat has come back
	task automatic wait_drained();
		drop_valid();
		while (trig_expected.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	function automatic logic signed [31:0] near_quarter();
		int k;
		int off;
		k = $urandom_range(0, 40) - 20;
		off = $urandom_range(0, 64) - 32;
		return k * ANG_HALF_PI + off;
	endfunction

	task automatic test_directed();
		logic signed [31:0] angles[] = '{0, 1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000,
			ANG_HALF_PI, -ANG_HALF_PI, ANG_PI, -ANG_PI, ANG_TWO_PI, 3 * ANG_HALF_PI};
		foreach (angles[i])
			for (int m = 0; m < 4; m++)
				if (i < 6 || m == MODE_TAN || m == MODE_COS)
					send_beat(2'(m), angles[i]);
		send_beat(MODE_RSVD, 32'sh1234_5678);
		wait_drained();
	endtask

	task automatic test_random(int count);
		logic signed [31:0] a;
		logic [1:0]         m;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: a = $urandom;
				4, 5, 6:    a = near_quarter();
				7, 8:       a = $urandom_range(0, 2 * ANG_TWO_PI) - ANG_TWO_PI;
				default:    a = $urandom_range(0, 255) - 128;
			endcase
			m = $urandom_range(0, 15) == 0 ? MODE_RSVD : 2'($urandom_range(0, 2));
			send_beat(m, a);
		end
	endtask

	// Stall the output for a long stretch while the input keeps offering beats
	task automatic test_backpressure();
		@(negedge clk);
		hold_left = HOLD_CYCLES;
		test_random(250);
		wait_drained();
	endtask

	// Drive the output ready, honoring a hold-off request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			res.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			res.ready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	// Compare each returned beat with the oldest expectation
	always @(posedge clk) begin
		trig_out_t want;
		if (arst_n && res.valid && res.ready) begin
			if (trig_expected.size() == 0) begin
				failed = 1;
				$display("unexpected result beat %h", res.result);
			end else begin
				want = trig_expected.pop_front();
				checked++;
				sat_count += want.saturated;
				if (res.result !== want.result || res.saturated !== want.saturated) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: result %h sat %b, expected %h sat %b",
							res.result, res.saturated, want.result, want.saturated);
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving either way
	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		cmd.valid = 1'b0;
		cmd.mode = MODE_SIN;
		cmd.angle = '0;
		res.ready = 1'b0;
		hold_left = 0;
		mismatches = 0;
		failed = 0;
		idle_cycles = 0;
		checked = 0;
		sat_count = 0;
		mode_count = '{default: 0};
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		send_idle_pct = 15;
		recv_idle_pct = 79;
		test_random(300);
		wait_drained();
		send_idle_pct = 79;
		recv_idle_pct = 15;
		test_random(300);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(350);
		test_backpressure();

		$display("covered %0d beats: sine %0d, cosine %0d, tangent %0d, reserved %0d",
			checked, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
		$display("tangent saturations seen: %0d, mismatches: %0d", sat_count, mismatches);
		if (failed == 0 && trig_expected.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
